[hdl/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FracBits = 14;
	localparam int Width    = 64;
	// divider works on 78-bit dividends, 2 quotient bits a stage
	localparam int DivW     = Width + FracBits;
	localparam int DivSteps = DivW / 2;

	typedef enum logic [3:0] {
		KIND_INT_TO_FIX = 4'd0,
		KIND_TRUNC      = 4'd1,
		KIND_ROUND      = 4'd2,
		KIND_ADD        = 4'd3,
		KIND_SUB        = 4'd4,
		KIND_MUL        = 4'd5,
		KIND_DIV        = 4'd6,
		KIND_ADD_INT    = 4'd7,
		KIND_SUB_INT    = 4'd8,
		KIND_MUL_INT    = 4'd9,
		KIND_DIV_INT    = 4'd10
	} kind_t;

	// per-item control carried along the pipeline
	typedef struct packed {
		logic [3:0] kind;
		logic       neg;
		logic       dz;
	} ctl_t;

endpackage

[hdl/fpa_div.sv]
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined unsigned restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module fpa_div
	import fpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [DivW-1:0]       dividend,
	input  logic [Width-1:0]      divisor,
	input  ctl_t                  in_ctl,
	input  logic [Width-1:0]      in_alt,
	output logic                  out_valid,
	output logic [Width-1:0]      quotient,
	output ctl_t                  out_ctl,
	output logic [Width-1:0]      out_alt
);

	logic                         vld_s  [DivSteps+1];
	logic [DivW-1:0]              num_s  [DivSteps+1];
	logic [Width:0]               rem_s  [DivSteps+1];
	logic [Width-1:0]             den_s  [DivSteps+1];
	ctl_t                         ctl_s  [DivSteps+1];
	logic [Width-1:0]             alt_s  [DivSteps+1];

	assign vld_s[0] = in_valid;
	assign num_s[0] = dividend;
	assign rem_s[0] = '0;
	assign den_s[0] = divisor;
	assign ctl_s[0] = in_ctl;
	assign alt_s[0] = in_alt;

	for (genvar g = 0; g < DivSteps; g++) begin : g_stage
		logic [Width:0]    r1, r2;
		logic [DivW-1:0]   n1, n2;
		always_comb begin
			r1 = {rem_s[g][Width-1:0], num_s[g][DivW-1]};
			n1 = {num_s[g][DivW-2:0], 1'b0};
			if (r1 >= {1'b0, den_s[g]}) begin
				r1    = r1 - {1'b0, den_s[g]};
				n1[0] = 1'b1;
			end
			r2 = {r1[Width-1:0], n1[DivW-1]};
			n2 = {n1[DivW-2:0], 1'b0};
			if (r2 >= {1'b0, den_s[g]}) begin
				r2    = r2 - {1'b0, den_s[g]};
				n2[0] = 1'b1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			num_s[g+1] <= n2;
			rem_s[g+1] <= r2;
			den_s[g+1] <= den_s[g];
			ctl_s[g+1] <= ctl_s[g];
			alt_s[g+1] <= alt_s[g];
		end
	end

	// quotient bits have shifted in at the bottom of the dividend word
	assign out_valid = vld_s[DivSteps];
	assign quotient  = num_s[DivSteps][Width-1:0];
	assign out_ctl   = ctl_s[DivSteps];
	assign out_alt   = alt_s[DivSteps];

endmodule

[hdl/fpa_mul.sv]
// ----------------------------------------------------------------------------
// fpa_mul
// Unsigned 64x64 multiplier: four 32x32 partial products, then a sum stage.
// ----------------------------------------------------------------------------
module fpa_mul
	import fpa_pkg::*;
(
	input  logic                 clk,
	input  logic [Width-1:0]     a,
	input  logic [Width-1:0]     b,
	output logic [2*Width-1:0]   p
);

	logic [63:0]  ll_s1, lh_s1, hl_s1, hh_s1;
	logic [127:0] mid_s2, lo_s2;

	always_ff @(posedge clk) begin
		ll_s1  <= a[31:0]  * b[31:0];
		lh_s1  <= a[31:0]  * b[63:32];
		hl_s1  <= a[63:32] * b[31:0];
		hh_s1  <= a[63:32] * b[63:32];
		mid_s2 <= ({64'd0, lh_s1} + {64'd0, hl_s1}) << 32;
		lo_s2  <= {hh_s1, ll_s1};
	end

	assign p = mid_s2 + lo_s2;

endmodule

[hdl/fixed_point_17_14_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu
// Q-format fixed-point ALU, 14 fraction bits, fully pipelined.
// ----------------------------------------------------------------------------
// channel | ports                         | handshake
// in      | kind, op_a, op_b, op_n        | start & !busy
// out     | value, div_by_zero            | done (one cycle)
//
// One transaction per cycle enters; busy is tied low. Every operation takes
// the same latency: one operand stage, the 39-stage radix-4 divider (which
// also carries the other operations' results along), two multiplier stages
// folded into that path and one output stage. The divider depth sets it.
// Reset clears only the valid bits. The receiver cannot stall, so nothing
// is held back.
// ----------------------------------------------------------------------------
module fixed_point_17_14_alu
	import fpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [3:0]           kind,
	input  logic signed [63:0]   op_a,
	input  logic signed [63:0]   op_b,
	input  logic signed [31:0]   op_n,
	output logic                 done,
	output logic signed [63:0]   value,
	output logic                 div_by_zero
);

	assign busy = 1'b0;

	// stage 1: magnitudes, signs and the cheap results
	logic [63:0] n_ext, nfix, mag_a, mag_b, mag_n;
	logic        neg_a, neg_b, neg_n;
	logic        vld_s1;
	ctl_t        ctl_s1;
	logic [DivW-1:0] dvd_s1;
	logic [63:0] dvs_s1, alt_s1, ma_s1, mb_s1;
	ctl_t        ctl_d;
	logic [DivW-1:0] dvd_d;
	logic [63:0] dvs_d, alt_d, mb_d;

	always_comb begin
		n_ext = {{32{op_n[31]}}, op_n};
		nfix  = n_ext << FracBits;
		neg_a = op_a[63];
		neg_b = op_b[63];
		neg_n = op_n[31];
		mag_a = neg_a ? 64'd0 - op_a : op_a;
		mag_b = neg_b ? 64'd0 - op_b : op_b;
		mag_n = neg_n ? 64'd0 - n_ext : n_ext;
		ctl_d.kind = kind;
		ctl_d.neg  = 1'b0;
		ctl_d.dz   = 1'b0;
		dvd_d      = '0;
		dvs_d      = 64'd1;
		alt_d      = '0;
		mb_d       = mag_b;
		unique case (kind)
			KIND_INT_TO_FIX: alt_d = nfix;
			KIND_TRUNC, KIND_ROUND: begin
				ctl_d.neg = neg_a;
				alt_d     = (mag_a + ((kind == KIND_ROUND) ?
					(64'd1 << (FracBits - 1)) : 64'd0)) >> FracBits;
			end
			KIND_ADD:     alt_d = op_a + op_b;
			KIND_SUB:     alt_d = op_a - op_b;
			KIND_MUL:     ctl_d.neg = neg_a ^ neg_b;
			KIND_DIV: begin
				ctl_d.neg = neg_a ^ neg_b;
				ctl_d.dz  = (op_b == 64'sd0);
				dvd_d     = {mag_a, {FracBits{1'b0}}};
				if (op_b != 64'sd0) dvs_d = mag_b;
			end
			KIND_ADD_INT: alt_d = op_a + nfix;
			KIND_SUB_INT: alt_d = op_a - nfix;
			KIND_MUL_INT: begin
				ctl_d.neg = neg_a ^ neg_n;
				mb_d      = mag_n;
			end
			KIND_DIV_INT: begin
				ctl_d.neg = neg_a ^ neg_n;
				ctl_d.dz  = (op_n == 32'sd0);
				dvd_d     = {{FracBits{1'b0}}, mag_a};
				if (op_n != 32'sd0) dvs_d = mag_n;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl_d;
		dvd_s1 <= dvd_d;
		dvs_s1 <= dvs_d;
		alt_s1 <= alt_d;
		ma_s1  <= mag_a;
		mb_s1  <= mb_d;
	end

	// multiplier runs alongside the first two divider stages
	logic [127:0] prod;
	fpa_mul u_mul (.clk(clk), .a(ma_s1), .b(mb_s1), .p(prod));

	// register the product into the divider's side path at its stage 2
	ctl_t        dctl;
	logic        dvld;
	logic [63:0] quot, dalt;
	logic [63:0] prod_q [DivSteps-2];

	fpa_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s1), .dividend(dvd_s1),
		.divisor(dvs_s1), .in_ctl(ctl_s1), .in_alt(alt_s1),
		.out_valid(dvld), .quotient(quot), .out_ctl(dctl), .out_alt(dalt)
	);

	// product delay lines, aligned with the divider output; the low word
	// serves multiply-by-integer, the scaled word fixed multiply
	always_ff @(posedge clk) begin
		prod_q[0] <= prod[63:0];
		for (int i = 1; i < DivSteps - 2; i++) prod_q[i] <= prod_q[i-1];
	end

	logic [63:0] prodhi_q [DivSteps-2];
	always_ff @(posedge clk) begin
		prodhi_q[0] <= prod[FracBits +: 64];
		for (int i = 1; i < DivSteps - 2; i++) prodhi_q[i] <= prodhi_q[i-1];
	end

	// output stage: pick, apply sign, wrap
	logic [63:0] mag_o, res_o;
	always_comb begin
		mag_o = '0;
		res_o = '0;
		unique case (dctl.kind)
			KIND_INT_TO_FIX, KIND_ADD, KIND_SUB, KIND_ADD_INT, KIND_SUB_INT:
				res_o = dalt;
			KIND_TRUNC, KIND_ROUND: begin
				mag_o = dctl.neg ? 64'd0 - dalt : dalt;
				res_o = {{32{mag_o[31]}}, mag_o[31:0]};
			end
			KIND_MUL: res_o = dctl.neg ? 64'd0 - prodhi_q[DivSteps-3]
				: prodhi_q[DivSteps-3];
			KIND_MUL_INT: res_o = dctl.neg ? 64'd0 - prod_q[DivSteps-3]
				: prod_q[DivSteps-3];
			KIND_DIV, KIND_DIV_INT:
				res_o = dctl.dz ? 64'd0 : (dctl.neg ? 64'd0 - quot : quot);
			default: res_o = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvld;
		end
	end

	always_ff @(posedge clk) begin
		value       <= res_o;
		div_by_zero <= dctl.dz;
	end

endmodule
